/* hw/rtl/i2p_pkg.sv */
// shared types, character constants and decode functions of the infix to postfix converter
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

   // operator codes as kept on the operator stack
   typedef enum logic [2:0] {
      OP_OPEN = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_POW  = 3'd5,
      OP_SIN  = 3'd6,
      OP_COS  = 3'd7
   } op_code_type;

   typedef enum logic [2:0] {
      KIND_ALNUM,
      KIND_OPEN,
      KIND_CLOSE,
      KIND_OPER,
      KIND_SPACE,
      KIND_OTHER
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FUNC,
      ST_CLASS,
      ST_TOKEN,
      ST_POP_CLOSE,
      ST_POP_OPER,
      ST_ENTRY,
      ST_LAST,
      ST_DRAIN,
      ST_FINISH
   } seq_state_type;

   // classified input word
   typedef struct packed {
      logic [7:0]  ch;
      logic        last;
      kind_type    kind;
      op_code_type op;
   } cmd_type;

   // result word
   typedef struct packed {
      logic [7:0] ch;
      logic       char_valid;
      logic       run_last;
      logic       expr_done;
      logic [1:0] err;
   } rsp_type;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_UNMATCHED = 2'd1;
   localparam logic [1:0] ERR_STACK     = 2'd2;
   localparam logic [1:0] ERR_TOKEN     = 2'd3;

   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_OPEN     = 8'h28;
   localparam logic [7:0] CH_CLOSE    = 8'h29;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_CARET    = 8'h5E;
   localparam logic [7:0] CH_DIGIT_LO = 8'h30;
   localparam logic [7:0] CH_DIGIT_HI = 8'h39;
   localparam logic [7:0] CH_UPPER_LO = 8'h41;
   localparam logic [7:0] CH_UPPER_HI = 8'h5A;
   localparam logic [7:0] CH_LOWER_LO = 8'h61;
   localparam logic [7:0] CH_LOWER_HI = 8'h7A;
   localparam logic [7:0] CH_S        = 8'h73;
   localparam logic [7:0] CH_I        = 8'h69;
   localparam logic [7:0] CH_N        = 8'h6E;
   localparam logic [7:0] CH_C        = 8'h63;
   localparam logic [7:0] CH_O        = 8'h6F;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPW         = $clog2(QUEUE_DEPTH);
   localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

   function automatic kind_type classify(input logic [7:0] ch);
      kind_type k;
      unique case (ch) inside
         [CH_DIGIT_LO:CH_DIGIT_HI],
         [CH_UPPER_LO:CH_UPPER_HI],
         [CH_LOWER_LO:CH_LOWER_HI]:                  k = KIND_ALNUM;
         CH_OPEN:                                    k = KIND_OPEN;
         CH_CLOSE:                                   k = KIND_CLOSE;
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: k = KIND_OPER;
         CH_SPACE:                                   k = KIND_SPACE;
         default:                                    k = KIND_OTHER;
      endcase
      return k;
   endfunction

   function automatic op_code_type char_op(input logic [7:0] ch);
      op_code_type op;
      unique case (ch)
         CH_PLUS:  op = OP_ADD;
         CH_MINUS: op = OP_SUB;
         CH_STAR:  op = OP_MUL;
         CH_SLASH: op = OP_DIV;
         CH_CARET: op = OP_POW;
         default:  op = OP_OPEN;
      endcase
      return op;
   endfunction

   function automatic logic [1:0] op_prio(input op_code_type op);
      logic [1:0] p;
      unique case (op) inside
         OP_ADD, OP_SUB:                 p = 2'd1;
         OP_MUL, OP_DIV, OP_SIN, OP_COS: p = 2'd2;
         OP_POW:                         p = 2'd3;
         default:                        p = 2'd0;
      endcase
      return p;
   endfunction

   // position of the trailing space in the text of a stack entry
   function automatic logic [1:0] entry_span(input op_code_type op);
      return (op == OP_SIN || op == OP_COS) ? 2'd3 : 2'd1;
   endfunction

   function automatic logic [7:0] entry_char(input op_code_type op, input logic [1:0] idx);
      logic [7:0] c;
      c = CH_SPACE;
      unique case (op)
         OP_SIN: begin
            case (idx)
               2'd0:    c = CH_S;
               2'd1:    c = CH_I;
               2'd2:    c = CH_N;
               default: c = CH_SPACE;
            endcase
         end
         OP_COS: begin
            case (idx)
               2'd0:    c = CH_C;
               2'd1:    c = CH_O;
               2'd2:    c = CH_S;
               default: c = CH_SPACE;
            endcase
         end
         default: begin
            if (idx == 2'd0) begin
               unique case (op)
                  OP_OPEN: c = CH_OPEN;
                  OP_ADD:  c = CH_PLUS;
                  OP_SUB:  c = CH_MINUS;
                  OP_MUL:  c = CH_STAR;
                  OP_DIV:  c = CH_SLASH;
                  default: c = CH_CARET;
               endcase
            end
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2p_front.sv */
// front end: input register and character classification
`timescale 1ns / 1ps
`default_nettype none

module i2p_front import i2p_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd
);

   logic    vld_ff;
   logic    vld_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    take;

   assign req_ready = !vld_ff || cmd_ready;
   assign take      = req_valid && req_ready;
   assign cmd_valid = vld_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      cmd_in.ch   = req_in_char;
      cmd_in.last = req_in_last;
      cmd_in.kind = classify(req_in_char);
      cmd_in.op   = char_op(req_in_char);
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd_ready) begin
         vld_in = 1'b0;
      end
      if (take) begin
         vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/i2p_queue.sv */
// short word queue between the front end and the sequencer
`timescale 1ns / 1ps
`default_nettype none

module i2p_queue import i2p_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_pop,
   output cmd_type out_cmd
);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ptr_ff;
   logic [QPW-1:0]   rd_ptr_ff;
   logic [QCW-1:0]   cnt_ff;
   logic             push;
   logic             pop;

   assign in_ready  = cnt_ff != QCW'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + QCW'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - QCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/i2p_back.sv */
// back end: operator stack, token buffer, emit sequencer and result registers
`timescale 1ns / 1ps
`default_nettype none

module i2p_back import i2p_pkg::*; #(
   parameter int STACK_DEPTH = 8,
   parameter int TOKEN_MAX   = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   localparam int SCW = $clog2(STACK_DEPTH + 1);
   localparam int SIW = $clog2(STACK_DEPTH);
   localparam int TCW = $clog2(TOKEN_MAX + 1);
   localparam int TIW = $clog2(TOKEN_MAX);

   seq_state_type state_ff;
   seq_state_type state_in;
   seq_state_type tok_ret_ff;
   seq_state_type ent_ret_ff;
   cmd_type       cmd_ff;

   op_code_type    op_stack_ff [STACK_DEPTH];
   logic [SCW-1:0] stack_cnt_ff;
   logic [SCW-1:0] paren_cnt_ff;
   logic [7:0]     token_buf_ff [TOKEN_MAX];
   logic [TCW-1:0] token_len_ff;
   logic [TCW-1:0] tok_idx_ff;
   op_code_type    ent_code_ff;
   logic [1:0]     ent_idx_ff;
   logic           discard_ff;
   logic           any_ff;

   rsp_type pend_ff;
   logic    pend_vld_ff;
   rsp_type out_ff;
   logic    out_vld_ff;

   logic           out_free;
   logic           can_emit;
   logic           emit;
   rsp_type        emit_res;
   logic           adv;
   logic           emit_go;
   logic           pend_move;
   logic           mark;
   logic           token_fn;
   op_code_type    fn_code;
   logic           stack_full;
   logic           has_tok;
   logic           tok_full;
   logic [SCW-1:0] stack_cnt_m1;
   logic [SIW-1:0] top_idx;
   logic [SIW-1:0] push_idx;
   logic [TIW-1:0] len_idx;
   logic [TIW-1:0] rd_idx;
   op_code_type    top_code;
   logic           pop_ok;

   assign out_free     = !out_vld_ff || rsp_ready;
   assign can_emit     = !pend_vld_ff || out_free;
   assign adv          = !emit || can_emit;
   assign emit_go      = emit && can_emit;
   assign pend_move    = pend_vld_ff && out_free && (pend_ff.run_last || emit_go);
   assign mark         = (state_ff == ST_FINISH) && any_ff;

   assign stack_cnt_m1 = stack_cnt_ff - SCW'(1);
   assign top_idx      = stack_cnt_m1[SIW-1:0];
   assign push_idx     = stack_cnt_ff[SIW-1:0];
   assign top_code     = op_stack_ff[top_idx];
   assign stack_full   = stack_cnt_ff == SCW'(STACK_DEPTH);
   assign len_idx      = token_len_ff[TIW-1:0];
   assign rd_idx       = tok_idx_ff[TIW-1:0];
   assign has_tok      = token_len_ff != '0;
   assign tok_full     = token_len_ff == TCW'(TOKEN_MAX);
   assign pop_ok       = (stack_cnt_ff != '0) && (op_prio(top_code) >= op_prio(cmd_ff.op));

   // a three letter token spelling sin or cos becomes a function
   assign token_fn = (token_len_ff == TCW'(3)) &&
                     (((token_buf_ff[0] == CH_S) && (token_buf_ff[1] == CH_I) &&
                       (token_buf_ff[2] == CH_N)) ||
                      ((token_buf_ff[0] == CH_C) && (token_buf_ff[1] == CH_O) &&
                       (token_buf_ff[2] == CH_S)));
   assign fn_code  = (token_buf_ff[0] == CH_S) ? OP_SIN : OP_COS;

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      if (adv) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  state_in = ST_FUNC;
               end
            end
            ST_FUNC: begin
               state_in = discard_ff ? ST_FINISH : ST_CLASS;
            end
            ST_CLASS: begin
               unique case (cmd_ff.kind)
                  KIND_OPEN, KIND_SPACE: state_in = has_tok ? ST_TOKEN : ST_LAST;
                  KIND_CLOSE: begin
                     if (paren_cnt_ff == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = has_tok ? ST_TOKEN : ST_POP_CLOSE;
                     end
                  end
                  KIND_OPER: state_in = has_tok ? ST_TOKEN : ST_POP_OPER;
                  default:   state_in = ST_LAST;
               endcase
            end
            ST_TOKEN: begin
               if (tok_idx_ff == token_len_ff) begin
                  state_in = tok_ret_ff;
               end
            end
            ST_POP_CLOSE: begin
               state_in = (top_code == OP_OPEN) ? ST_LAST : ST_ENTRY;
            end
            ST_POP_OPER: begin
               state_in = pop_ok ? ST_ENTRY : ST_LAST;
            end
            ST_ENTRY: begin
               if (ent_idx_ff == entry_span(ent_code_ff)) begin
                  state_in = ent_ret_ff;
               end
            end
            ST_LAST: begin
               if (!cmd_ff.last) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = has_tok ? ST_TOKEN : ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_in = (stack_cnt_ff != '0) ? ST_ENTRY : ST_FINISH;
            end
            ST_FINISH: begin
               state_in = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // outputs of the sequencer: queue pop and the word to emit
   always_comb begin
      q_pop    = 1'b0;
      emit     = 1'b0;
      emit_res = '0;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
         end
         ST_FUNC: begin
            if (discard_ff) begin
               if (cmd_ff.last) begin
                  emit         = 1'b1;
                  emit_res.err = ERR_UNMATCHED;
               end
            end else if (token_fn && stack_full) begin
               emit         = 1'b1;
               emit_res.err = ERR_STACK;
            end
         end
         ST_CLASS: begin
            unique case (cmd_ff.kind)
               KIND_ALNUM: begin
                  if (tok_full) begin
                     emit         = 1'b1;
                     emit_res.err = ERR_TOKEN;
                  end
               end
               KIND_OPEN: begin
                  if (!has_tok && stack_full) begin
                     emit         = 1'b1;
                     emit_res.err = ERR_STACK;
                  end
               end
               KIND_CLOSE: begin
                  if (paren_cnt_ff == '0) begin
                     emit         = 1'b1;
                     emit_res.err = ERR_UNMATCHED;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_TOKEN: begin
            emit                = 1'b1;
            emit_res.char_valid = 1'b1;
            emit_res.ch = (tok_idx_ff == token_len_ff) ? CH_SPACE : token_buf_ff[rd_idx];
         end
         ST_POP_CLOSE: begin
            if (top_code != OP_OPEN) begin
               emit                = 1'b1;
               emit_res.char_valid = 1'b1;
               emit_res.ch         = entry_char(top_code, 2'd0);
            end
         end
         ST_POP_OPER: begin
            if (pop_ok) begin
               emit                = 1'b1;
               emit_res.char_valid = 1'b1;
               emit_res.ch         = entry_char(top_code, 2'd0);
            end else if (stack_full) begin
               emit         = 1'b1;
               emit_res.err = ERR_STACK;
            end
         end
         ST_ENTRY: begin
            emit                = 1'b1;
            emit_res.char_valid = 1'b1;
            emit_res.ch         = entry_char(ent_code_ff, ent_idx_ff);
         end
         ST_DRAIN: begin
            if (stack_cnt_ff != '0) begin
               emit                = 1'b1;
               emit_res.char_valid = 1'b1;
               emit_res.ch         = entry_char(top_code, 2'd0);
            end
         end
         ST_FINISH: begin
            // an expression that yields nothing still closes with a status word
            if (cmd_ff.last && !any_ff) begin
               emit               = 1'b1;
               emit_res.err       = ERR_NONE;
               emit_res.run_last  = 1'b1;
               emit_res.expr_done = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tok_ret_ff   <= ST_IDLE;
         ent_ret_ff   <= ST_IDLE;
         stack_cnt_ff <= '0;
         paren_cnt_ff <= '0;
         token_len_ff <= '0;
         tok_idx_ff   <= '0;
         discard_ff   <= 1'b0;
         any_ff       <= 1'b0;
         pend_vld_ff  <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (adv && state_in == ST_TOKEN && state_ff != ST_TOKEN) begin
            tok_ret_ff <= state_ff;
         end
         if (adv && state_in == ST_ENTRY && state_ff != ST_ENTRY) begin
            ent_ret_ff <= state_ff;
         end

         if (q_pop) begin
            any_ff <= 1'b0;
         end else if (emit_go) begin
            any_ff <= 1'b1;
         end

         if (pend_move) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end

         if (emit_go) begin
            pend_vld_ff <= 1'b1;
         end else if (pend_move) begin
            pend_vld_ff <= 1'b0;
         end

         if (adv) begin
            unique case (state_ff)
               ST_FUNC: begin
                  if (!discard_ff && token_fn) begin
                     if (!stack_full) begin
                        stack_cnt_ff <= stack_cnt_ff + SCW'(1);
                     end
                     token_len_ff <= '0;
                  end
               end
               ST_CLASS: begin
                  unique case (cmd_ff.kind)
                     KIND_ALNUM: begin
                        if (!tok_full) begin
                           token_len_ff <= token_len_ff + TCW'(1);
                        end
                     end
                     KIND_OPEN: begin
                        if (!has_tok && !stack_full) begin
                           stack_cnt_ff <= stack_cnt_ff + SCW'(1);
                           paren_cnt_ff <= paren_cnt_ff + SCW'(1);
                        end
                     end
                     KIND_CLOSE: begin
                        if (paren_cnt_ff == '0) begin
                           stack_cnt_ff <= '0;
                           paren_cnt_ff <= '0;
                           token_len_ff <= '0;
                           discard_ff   <= !cmd_ff.last;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               ST_TOKEN: begin
                  if (tok_idx_ff == token_len_ff) begin
                     tok_idx_ff   <= '0;
                     token_len_ff <= '0;
                  end else begin
                     tok_idx_ff <= tok_idx_ff + TCW'(1);
                  end
               end
               ST_POP_CLOSE: begin
                  stack_cnt_ff <= stack_cnt_m1;
                  if (top_code == OP_OPEN) begin
                     paren_cnt_ff <= paren_cnt_ff - SCW'(1);
                  end
               end
               ST_POP_OPER: begin
                  if (pop_ok) begin
                     stack_cnt_ff <= stack_cnt_m1;
                  end else if (!stack_full) begin
                     stack_cnt_ff <= stack_cnt_ff + SCW'(1);
                  end
               end
               ST_DRAIN: begin
                  if (stack_cnt_ff != '0) begin
                     stack_cnt_ff <= stack_cnt_m1;
                     if (top_code == OP_OPEN) begin
                        paren_cnt_ff <= paren_cnt_ff - SCW'(1);
                     end
                  end
               end
               ST_FINISH: begin
                  if (cmd_ff.last) begin
                     stack_cnt_ff <= '0;
                     paren_cnt_ff <= '0;
                     token_len_ff <= '0;
                     discard_ff   <= 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end

      if (pend_move) begin
         out_ff <= pend_ff;
      end

      if (emit_go) begin
         pend_ff <= emit_res;
      end else if (mark) begin
         pend_ff.run_last  <= 1'b1;
         pend_ff.expr_done <= cmd_ff.last;
      end

      if (adv) begin
         case (state_ff)
            ST_FUNC: begin
               if (!discard_ff && token_fn && !stack_full) begin
                  op_stack_ff[push_idx] <= fn_code;
               end
            end
            ST_CLASS: begin
               if (cmd_ff.kind == KIND_ALNUM && !tok_full) begin
                  token_buf_ff[len_idx] <= cmd_ff.ch;
               end
               if (cmd_ff.kind == KIND_OPEN && !has_tok && !stack_full) begin
                  op_stack_ff[push_idx] <= OP_OPEN;
               end
            end
            ST_POP_CLOSE, ST_DRAIN: begin
               ent_code_ff <= top_code;
               ent_idx_ff  <= 2'd1;
            end
            ST_POP_OPER: begin
               ent_code_ff <= top_code;
               ent_idx_ff  <= 2'd1;
               if (!pop_ok && !stack_full) begin
                  op_stack_ff[push_idx] <= cmd_ff.op;
               end
            end
            ST_ENTRY: begin
               ent_idx_ff <= ent_idx_ff + 2'd1;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/infix_to_postfix_converter.sv */
// infix to postfix converter: front end, word queue and stack sequencer
// a word passes the front register, the queue, the sequencer and the result registers
// the single sequencer takes one input word at a time and pops the next only from idle;
// it stalls while the pending and output result registers cannot take a word
// a 4-word queue lets the input side run ahead while the sequencer emits
// synchronous reset empties the stack, token, queue and result registers; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter import i2p_pkg::*; #(
   parameter int STACK_DEPTH = 8,
   parameter int TOKEN_MAX   = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_run_last,
   output logic       rsp_expr_done,
   output logic [1:0] rsp_error_code
);

   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;
   rsp_type rsp_word;

   i2p_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_char (req_in_char),
      .req_in_last (req_in_last),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready),
      .cmd         (front_cmd)
   );

   i2p_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_cmd   (q_cmd)
   );

   i2p_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .TOKEN_MAX   (TOKEN_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_out_char   = rsp_word.ch;
   assign rsp_char_valid = rsp_word.char_valid;
   assign rsp_run_last   = rsp_word.run_last;
   assign rsp_expr_done  = rsp_word.expr_done;
   assign rsp_error_code = rsp_word.err;

   // end of expression is always the last word of its input word
   a_done_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expr_done |-> rsp_run_last)
      else $error("expr_done without run_last");

   // status words carry no character
   a_marker_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_out_char == 8'h00)
      else $error("status word with a character");

   // character words carry no error
   a_char_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |-> rsp_error_code == ERR_NONE)
      else $error("character word with an error code");

   // a character word that closes an expression is always a space
   a_done_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expr_done && rsp_char_valid |-> rsp_out_char == CH_SPACE)
      else $error("expression closed on a non-space character");

endmodule

`default_nettype wire

/* tb/infix_to_postfix_converter_tb.sv */
// self-checking testbench for the infix to postfix converter: expressions in, postfix text checked
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
   import i2p_pkg::*;

   localparam int STACK_DEPTH    = 8;
   localparam int TOKEN_MAX      = 8;
   localparam int ITEM_TARGET    = 330;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 20;

   // tracks converter state and holds the postfix words still to come
   class postfix_checker;
      op_code_type op_stack [STACK_DEPTH];
      int          stack_count;
      logic [7:0]  token_buf [TOKEN_MAX];
      int          token_len;
      bit          discarding;
      rsp_type     run_words[$];
      rsp_type     expected_text[$];
      int          failures;
      int          words_checked;
      int          markers [4];

      function new();
         stack_count = 0;
         token_len   = 0;
         discarding  = 1'b0;
         failures    = 0;
         words_checked = 0;
         foreach (markers[i]) markers[i] = 0;
      endfunction

      function int pending();
         return expected_text.size();
      endfunction

      function void emit(logic [7:0] ch, logic valid, logic [1:0] err);
         rsp_type w;
         w.ch         = ch;
         w.char_valid = valid;
         w.run_last   = 1'b0;
         w.expr_done  = 1'b0;
         w.err        = err;
         run_words.push_back(w);
      endfunction

      function logic [1:0] rank(op_code_type op);
         case (op)
            OP_ADD, OP_SUB:                 return 2'd1;
            OP_MUL, OP_DIV, OP_SIN, OP_COS: return 2'd2;
            OP_POW:                         return 2'd3;
            default:                        return 2'd0;
         endcase
      endfunction

      function void flush_token();
         if (token_len == 0) return;
         for (int i = 0; i < token_len; i++) emit(token_buf[i], 1'b1, ERR_NONE);
         token_len = 0;
         emit(CH_SPACE, 1'b1, ERR_NONE);
      endfunction

      function void push_op(op_code_type op);
         if (stack_count < STACK_DEPTH) begin
            op_stack[stack_count] = op;
            stack_count++;
         end else begin
            emit(8'h00, 1'b0, ERR_STACK);
         end
      endfunction

      function void pop_emit();
         op_code_type op;
         stack_count--;
         op = op_stack[stack_count];
         case (op)
            OP_SIN: begin
               emit(CH_S, 1'b1, ERR_NONE);
               emit(CH_I, 1'b1, ERR_NONE);
               emit(CH_N, 1'b1, ERR_NONE);
            end
            OP_COS: begin
               emit(CH_C, 1'b1, ERR_NONE);
               emit(CH_O, 1'b1, ERR_NONE);
               emit(CH_S, 1'b1, ERR_NONE);
            end
            OP_OPEN: emit(CH_OPEN, 1'b1, ERR_NONE);
            OP_ADD:  emit(CH_PLUS, 1'b1, ERR_NONE);
            OP_SUB:  emit(CH_MINUS, 1'b1, ERR_NONE);
            OP_MUL:  emit(CH_STAR, 1'b1, ERR_NONE);
            OP_DIV:  emit(CH_SLASH, 1'b1, ERR_NONE);
            default: emit(CH_CARET, 1'b1, ERR_NONE);
         endcase
         emit(CH_SPACE, 1'b1, ERR_NONE);
      endfunction

      function bit decode_oper(logic [7:0] c, output op_code_type op);
         op = OP_OPEN;
         case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            CH_CARET: op = OP_POW;
            default:  return 1'b0;
         endcase
         return 1'b1;
      endfunction

      // returns 1 unless the word is one the block simply ignores
      function bit take_char(logic [7:0] c, logic last);
         op_code_type op;
         bit          found;
         bit          aborted;
         bit          alnum;
         bit          is_op;
         bit          counts;
         logic [1:0]  p;
         run_words.delete();
         aborted = 1'b0;
         alnum = (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) || (c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
                 (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
         is_op = decode_oper(c, op);
         counts = last || alnum || is_op || c == CH_OPEN || c == CH_CLOSE || c == CH_SPACE;
         if (discarding) begin
            if (!last) return 1'b0;
            emit(8'h00, 1'b0, ERR_UNMATCHED);
            aborted = 1'b1;
         end else begin
            // a finished sin or cos token turns into a function on the next word
            if (token_len == 3 && token_buf[2] == (token_buf[0] == CH_S ? CH_N : CH_S) &&
                ((token_buf[0] == CH_S && token_buf[1] == CH_I) ||
                 (token_buf[0] == CH_C && token_buf[1] == CH_O))) begin
               push_op(token_buf[0] == CH_S ? OP_SIN : OP_COS);
               token_len = 0;
            end
            if (alnum) begin
               if (token_len < TOKEN_MAX) begin
                  token_buf[token_len] = c;
                  token_len++;
               end else begin
                  emit(8'h00, 1'b0, ERR_TOKEN);
               end
            end else if (c == CH_OPEN) begin
               flush_token();
               push_op(OP_OPEN);
            end else if (c == CH_CLOSE) begin
               found = 1'b0;
               for (int i = 0; i < stack_count; i++) if (op_stack[i] == OP_OPEN) found = 1'b1;
               if (!found) begin
                  emit(8'h00, 1'b0, ERR_UNMATCHED);
                  stack_count = 0;
                  token_len   = 0;
                  discarding  = !last;
                  aborted     = 1'b1;
               end else begin
                  flush_token();
                  while (stack_count > 0 && op_stack[stack_count-1] != OP_OPEN) pop_emit();
                  if (stack_count > 0) stack_count--;
               end
            end else if (is_op) begin
               p = rank(op);
               flush_token();
               while (stack_count > 0 && rank(op_stack[stack_count-1]) >= p) pop_emit();
               push_op(op);
            end else if (c == CH_SPACE) begin
               flush_token();
            end
            if (last && !aborted) begin
               flush_token();
               while (stack_count > 0) pop_emit();
            end
         end
         if (last) begin
            if (run_words.size() == 0) emit(8'h00, 1'b0, ERR_NONE);
            run_words[run_words.size()-1].expr_done = 1'b1;
            stack_count = 0;
            token_len   = 0;
            discarding  = 1'b0;
         end
         if (run_words.size() > 0) run_words[run_words.size()-1].run_last = 1'b1;
         foreach (run_words[i]) begin
            if (!run_words[i].char_valid) markers[run_words[i].err]++;
            expected_text.push_back(run_words[i]);
         end
         return counts;
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         words_checked++;
         if (expected_text.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected word: ch=%h valid=%b run_last=%b done=%b err=%0d",
                        got.ch, got.char_valid, got.run_last, got.expr_done, got.err);
            return;
         end
         want = expected_text.pop_front();
         if (got.ch != want.ch || got.char_valid != want.char_valid ||
             got.run_last != want.run_last || got.expr_done != want.expr_done ||
             got.err != want.err) begin
            failures++;
            if (failures <= 10)
               $display("mismatch at word %0d: exp ch=%h valid=%b run_last=%b done=%b err=%0d, got ch=%h valid=%b run_last=%b done=%b err=%0d",
                        words_checked, want.ch, want.char_valid, want.run_last, want.expr_done,
                        want.err, got.ch, got.char_valid, got.run_last, got.expr_done, got.err);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_char = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_char_valid;
   logic       rsp_run_last;
   logic       rsp_expr_done;
   logic [1:0] rsp_error_code;

   postfix_checker sb = new;
   logic       calm = 1'b0;
   logic       hold_armed = 1'b0;
   bit         hold_taken = 1'b0;
   int         hold_left = 0;
   int         quiet_cycles = 0;
   int         items_sent = 0;
   int         exprs_sent = 0;
   logic [7:0] expr_chars[$];

   always #6 clock = ~clock;

   infix_to_postfix_converter #(
      .STACK_DEPTH (STACK_DEPTH),
      .TOKEN_MAX   (TOKEN_MAX)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_char    (req_in_char),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_expr_done  (rsp_expr_done),
      .rsp_error_code (rsp_error_code)
   );

   // receiver: random stalls, one long hold-off once the sender asks for it
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_armed && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 18);
      end
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_word('{ch: rsp_out_char, char_valid: rsp_char_valid,
                            run_last: rsp_run_last, expr_done: rsp_expr_done,
                            err: rsp_error_code});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_char(logic [7:0] c, logic last);
      while (!calm && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= c;
      req_in_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (sb.take_char(c, last)) items_sent++;
      if (last) exprs_sent++;
      calm <= (items_sent >= 150 && items_sent < 220);
      if (items_sent == 100) hold_armed <= 1'b1;
   endtask

   task automatic send_text(string s, bit finish);
      for (int i = 0; i < s.len(); i++) send_char(s[i], finish && i == s.len() - 1);
   endtask

   function automatic logic [7:0] rand_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 10) return CH_DIGIT_LO + r;
      if (r < 36) return CH_UPPER_LO + (r - 10);
      return CH_LOWER_LO + (r - 36);
   endfunction

   function automatic logic [7:0] rand_oper();
      case ($urandom_range(0, 4))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         3:       return CH_SLASH;
         default: return CH_CARET;
      endcase
   endfunction

   // mostly well-formed expressions with random content, some noise and broken ones
   task automatic build_expr();
      int depth;
      int terms;
      int n_open;
      int len;
      expr_chars.delete();
      if ($urandom_range(0, 15) == 0) begin
         len = $urandom_range(1, 8);
         repeat (len) expr_chars.push_back($urandom_range(0, 255));
         return;
      end
      depth = 0;
      terms = $urandom_range(1, 6);
      for (int t = 0; t < terms; t++) begin
         if (t > 0) begin
            expr_chars.push_back(rand_oper());
            if ($urandom_range(0, 3) == 0) expr_chars.push_back(CH_SPACE);
         end
         n_open = ($urandom_range(0, 11) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 1);
         repeat (n_open) begin
            case ($urandom_range(0, 5))
               0: begin
                  expr_chars.push_back(CH_S); expr_chars.push_back(CH_I);
                  expr_chars.push_back(CH_N); expr_chars.push_back(CH_OPEN);
                  depth++;
               end
               1: begin
                  expr_chars.push_back(CH_C); expr_chars.push_back(CH_O);
                  expr_chars.push_back(CH_S); expr_chars.push_back(CH_OPEN);
                  depth++;
               end
               // function name run straight into its argument
               2: begin
                  expr_chars.push_back(CH_S); expr_chars.push_back(CH_I);
                  expr_chars.push_back(CH_N);
               end
               3: begin
                  expr_chars.push_back(CH_C); expr_chars.push_back(CH_O);
                  expr_chars.push_back(CH_S); expr_chars.push_back(CH_SPACE);
               end
               default: begin
                  expr_chars.push_back(CH_OPEN);
                  depth++;
               end
            endcase
         end
         len = ($urandom_range(0, 12) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 3);
         repeat (len) expr_chars.push_back(rand_alnum());
         if ($urandom_range(0, 9) == 0) expr_chars.push_back($urandom_range(0, 255));
         if ($urandom_range(0, 5) == 0) expr_chars.push_back(CH_SPACE);
         while (depth > 0 && $urandom_range(0, 2) == 0) begin
            expr_chars.push_back(CH_CLOSE);
            depth--;
         end
      end
      while (depth > 0 && $urandom_range(0, 3) != 0) begin
         expr_chars.push_back(CH_CLOSE);
         depth--;
      end
      // stray close with trailing words that ought to be dropped
      if ($urandom_range(0, 9) == 0) begin
         expr_chars.push_back(CH_CLOSE);
         len = $urandom_range(0, 3);
         repeat (len) expr_chars.push_back(rand_alnum());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // the -, / and ^ operators, both functions, overflow of the operator stack, parens
      send_text("sin(cos((a-b/c^d()", 1'b1);
      // over-long token with a stray byte inside it, unmatched close, then drop to the end
      send_text("a* b+Zz012", 1'b0);
      send_char(8'hFF, 1'b0);
      send_text("3456)", 1'b0);
      send_char(8'h00, 1'b1);
      // expression that gives no text at all
      send_text(" ", 1'b1);

      while (items_sent < ITEM_TARGET) begin
         build_expr();
         foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1);
         if (exprs_sent == 15) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.pending() != 0) $display("%0d words never arrived", sb.pending());
      $display("run: %0d words in over %0d expressions, %0d result words checked",
               items_sent, exprs_sent, sb.words_checked);
      $display("status words: %0d empty, %0d unmatched close, %0d stack full, %0d token long",
               sb.markers[ERR_NONE], sb.markers[ERR_UNMATCHED], sb.markers[ERR_STACK],
               sb.markers[ERR_TOKEN]);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d failures", sb.failures);
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/i2p_pkg.sv
hw/rtl/i2p_front.sv
hw/rtl/i2p_queue.sv
hw/rtl/i2p_back.sv
hw/rtl/infix_to_postfix_converter.sv
tb/infix_to_postfix_converter_tb.sv
